// ===== design/irt_pkg.sv =====
// Shared types, codes and constants for the interval round timer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package irt_pkg;

  // request codes of the req_type field; codes 6 and 7 are ignored
  localparam logic [2:0] REQ_ENTER  = 3'd0;
  localparam logic [2:0] REQ_ROTATE = 3'd1;
  localparam logic [2:0] REQ_PRESS  = 3'd2;
  localparam logic [2:0] REQ_INC    = 3'd3;
  localparam logic [2:0] REQ_DEC    = 3'd4;
  localparam logic [2:0] REQ_TICK   = 3'd5;

  // phase codes as reported on phase_now
  localparam logic [2:0] PH_SETUP_CODE  = 3'd0;
  localparam logic [2:0] PH_WORK_CODE   = 3'd1;
  localparam logic [2:0] PH_REST_CODE   = 3'd2;
  localparam logic [2:0] PH_PAUSED_CODE = 3'd3;
  localparam logic [2:0] PH_DONE_CODE   = 3'd4;

  // setup fields
  localparam logic [2:0] FLD_WORK_MIN = 3'd0;
  localparam logic [2:0] FLD_WORK_SEC = 3'd1;
  localparam logic [2:0] FLD_REST_MIN = 3'd2;
  localparam logic [2:0] FLD_REST_SEC = 3'd3;
  localparam logic [2:0] FLD_ROUNDS   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_WORK   = 2'd0;
  localparam logic [1:0] REG_REST   = 2'd1;
  localparam logic [1:0] REG_ROUNDS = 2'd2;

  localparam logic [12:0] MAX_TOTAL    = 13'd5999;
  localparam logic [6:0]  MAX_MINS     = 7'd99;
  localparam logic [6:0]  MAX_ROUNDS   = 7'd99;
  localparam logic [12:0] DEFAULT_WORK = 13'd30;
  localparam logic [12:0] SEC_PER_MIN  = 13'd60;
  localparam logic [22:0] MS_PER_SEC   = 23'd1000;
  // floor(65536 / 60): quotient estimate is exact or one short
  localparam logic [10:0] RECIP_60     = 11'd1092;

  typedef enum logic [4:0] {
    PH_SETUP  = 5'b00001,
    PH_WORK   = 5'b00010,
    PH_REST   = 5'b00100,
    PH_PAUSED = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [6:0] mins;
    logic [5:0] secs;
  } min_sec_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [6:0]  step;
    logic [15:0] elapsed;
  } item_t;

  // settings as loaded on enter, already substituted and saturated
  typedef struct packed {
    logic [12:0] work_len;
    min_sec_t    work_ms;
    logic [12:0] rest_len;
    min_sec_t    rest_ms;
    logic [6:0]  rounds;
  } cfg_load_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  field;
    logic [6:0]  round_now;
    logic [6:0]  rounds_total;
    logic [12:0] work_seconds;
    logic [12:0] rest_seconds;
    logic [23:0] time_left;
    logic        save;
  } result_t;

  // split a total of at most MAX_TOTAL seconds into minutes and seconds
  function automatic min_sec_t split_time(input logic [12:0] total);
    logic [23:0] prod;
    logic [7:0]  q;
    logic [12:0] r;
    min_sec_t    res;
    prod = 24'(total) * 24'(RECIP_60);
    q    = prod[23:16];
    r    = total - 13'(q) * SEC_PER_MIN;
    if (r >= SEC_PER_MIN) begin
      q = q + 8'd1;
      r = r - SEC_PER_MIN;
    end
    res.mins = q[6:0];
    res.secs = r[5:0];
    return res;
  endfunction

  function automatic logic [2:0] phase_code(input phase_e ph);
    logic [2:0] code;
    unique case (ph)
      PH_SETUP:  code = PH_SETUP_CODE;
      PH_WORK:   code = PH_WORK_CODE;
      PH_REST:   code = PH_REST_CODE;
      PH_PAUSED: code = PH_PAUSED_CODE;
      PH_DONE:   code = PH_DONE_CODE;
      default:   code = PH_SETUP_CODE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== design/irt_cfg.sv =====
// Configuration registers of the interval round timer on an APB-style port.
// Depends on irt_pkg; presents the settings that an enter request loads.
`default_nettype none

module irt_cfg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output irt_pkg::cfg_load_t      load_o
);

  logic [12:0] work_q;
  logic [12:0] rest_q;
  logic [6:0]  rounds_q;
  logic        wr_en;
  logic [1:0]  reg_idx;
  logic [12:0] work_sat;
  logic [12:0] rest_sat;
  logic [6:0]  rounds_sub;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q   <= '0;
      rest_q   <= '0;
      rounds_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        irt_pkg::REG_WORK:   work_q   <= pwdata[12:0];
        irt_pkg::REG_REST:   rest_q   <= pwdata[12:0];
        irt_pkg::REG_ROUNDS: rounds_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      irt_pkg::REG_WORK:   prdata = 32'(work_q);
      irt_pkg::REG_REST:   prdata = 32'(rest_q);
      irt_pkg::REG_ROUNDS: prdata = 32'(rounds_q);
      default:             prdata = '0;
    endcase
  end

  // substitute zero, then saturate
  always_comb begin
    if (work_q == '0) begin
      work_sat = irt_pkg::DEFAULT_WORK;
    end else if (work_q > irt_pkg::MAX_TOTAL) begin
      work_sat = irt_pkg::MAX_TOTAL;
    end else begin
      work_sat = work_q;
    end
    rest_sat = (rest_q > irt_pkg::MAX_TOTAL) ? irt_pkg::MAX_TOTAL : rest_q;
    if (rounds_q == '0) begin
      rounds_sub = 7'd1;
    end else if (rounds_q > irt_pkg::MAX_ROUNDS) begin
      rounds_sub = irt_pkg::MAX_ROUNDS;
    end else begin
      rounds_sub = rounds_q;
    end
  end

  assign load_o.work_len = work_sat;
  assign load_o.work_ms  = irt_pkg::split_time(work_sat);
  assign load_o.rest_len = rest_sat;
  assign load_o.rest_ms  = irt_pkg::split_time(rest_sat);
  assign load_o.rounds   = rounds_sub;

endmodule

`default_nettype wire

// ===== design/irt_core.sv =====
// Timer state and its single-pass update for one request.
// Depends on irt_pkg; driven by the input stage of the top level.
`default_nettype none

module irt_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire irt_pkg::item_t     item_i,
  input  wire irt_pkg::cfg_load_t load_i,
  output irt_pkg::result_t        result_o
);

  irt_pkg::phase_e   phase_q, phase_d;
  irt_pkg::phase_e   resume_q, resume_d;
  logic [2:0]        field_q, field_d;
  logic [12:0]       work_len_q, work_len_d;
  irt_pkg::min_sec_t work_t_q, work_t_d;
  logic [12:0]       rest_len_q, rest_len_d;
  irt_pkg::min_sec_t rest_t_q, rest_t_d;
  logic [6:0]        limit_q, limit_d;
  logic [6:0]        index_q, index_d;
  logic [23:0]       rem_q, rem_d;
  logic              save;

  // edit datapath
  logic              ed_work;
  logic              ed_min;
  irt_pkg::min_sec_t ed_src;
  logic signed [8:0] min_sum;
  logic signed [7:0] sec_sum;
  logic [6:0]        min_new;
  logic [5:0]        sec_new;
  irt_pkg::min_sec_t ed_res;
  logic [12:0]       ed_tot;
  logic signed [8:0] rnd_sum;
  logic [6:0]        rnd_new;

  // countdown datapath
  logic [24:0]       rem_sub;
  logic              rem_out;
  logic [23:0]       work_ms;
  logic [23:0]       rest_ms;

  assign ed_work = (field_q == irt_pkg::FLD_WORK_MIN) || (field_q == irt_pkg::FLD_WORK_SEC);
  assign ed_min  = (field_q == irt_pkg::FLD_WORK_MIN) || (field_q == irt_pkg::FLD_REST_MIN);
  assign ed_src  = ed_work ? work_t_q : rest_t_q;

  assign min_sum = $signed({2'b00, ed_src.mins}) + $signed({{2{item_i.step[6]}}, item_i.step});
  assign sec_sum = $signed({2'b00, ed_src.secs}) + $signed({item_i.step[6], item_i.step});
  assign rnd_sum = $signed({2'b00, limit_q}) + $signed({{2{item_i.step[6]}}, item_i.step});

  always_comb begin
    if (min_sum < 0) begin
      min_new = '0;
    end else if (min_sum > $signed(9'(irt_pkg::MAX_MINS))) begin
      min_new = irt_pkg::MAX_MINS;
    end else begin
      min_new = min_sum[6:0];
    end

    // wrap seconds into 0..59; the sum spans -64..122
    if (sec_sum < -8'sd60) begin
      sec_new = 6'(sec_sum + 8'sd120);
    end else if (sec_sum < 0) begin
      sec_new = 6'(sec_sum + 8'sd60);
    end else if (sec_sum >= 8'sd120) begin
      sec_new = 6'(sec_sum - 8'sd120);
    end else if (sec_sum >= 8'sd60) begin
      sec_new = 6'(sec_sum - 8'sd60);
    end else begin
      sec_new = sec_sum[5:0];
    end

    ed_res.mins = ed_min ? min_new : ed_src.mins;
    ed_res.secs = ed_min ? ed_src.secs : sec_new;
    ed_tot      = 13'(ed_res.mins) * irt_pkg::SEC_PER_MIN + 13'(ed_res.secs);
    // work never drops below one second; 99:59 is the ceiling by construction
    if (ed_work && ed_tot == '0) begin
      ed_tot      = 13'd1;
      ed_res.secs = 6'd1;
    end

    if (rnd_sum < 9'sd1) begin
      rnd_new = 7'd1;
    end else if (rnd_sum > $signed(9'(irt_pkg::MAX_ROUNDS))) begin
      rnd_new = irt_pkg::MAX_ROUNDS;
    end else begin
      rnd_new = rnd_sum[6:0];
    end
  end

  assign rem_sub = {rem_q[23], rem_q} - {9'b0, item_i.elapsed};
  assign rem_out = rem_sub[24] || (rem_sub == '0);
  assign work_ms = {1'b0, 23'(work_len_q) * irt_pkg::MS_PER_SEC};
  assign rest_ms = {1'b0, 23'(rest_len_q) * irt_pkg::MS_PER_SEC};

  always_comb begin
    phase_d    = phase_q;
    resume_d   = resume_q;
    field_d    = field_q;
    work_len_d = work_len_q;
    work_t_d   = work_t_q;
    rest_len_d = rest_len_q;
    rest_t_d   = rest_t_q;
    limit_d    = limit_q;
    index_d    = index_q;
    rem_d      = rem_q;
    save       = 1'b0;

    case (item_i.req)
      irt_pkg::REQ_ENTER: begin
        work_len_d = load_i.work_len;
        work_t_d   = load_i.work_ms;
        rest_len_d = load_i.rest_len;
        rest_t_d   = load_i.rest_ms;
        limit_d    = load_i.rounds;
        phase_d    = irt_pkg::PH_SETUP;
        field_d    = irt_pkg::FLD_WORK_MIN;
        index_d    = '0;
        rem_d      = '0;
      end
      irt_pkg::REQ_ROTATE: begin
        if (phase_q == irt_pkg::PH_SETUP) begin
          if (field_q == irt_pkg::FLD_ROUNDS) begin
            limit_d = rnd_new;
          end else if (ed_work) begin
            work_len_d = ed_tot;
            work_t_d   = ed_res;
          end else begin
            rest_len_d = ed_tot;
            rest_t_d   = ed_res;
          end
        end
      end
      irt_pkg::REQ_PRESS: begin
        if (phase_q == irt_pkg::PH_SETUP) begin
          field_d = (field_q == irt_pkg::FLD_ROUNDS) ? irt_pkg::FLD_WORK_MIN
                                                     : field_q + 3'd1;
        end else begin
          save    = 1'b1;
          phase_d = irt_pkg::PH_SETUP;
          field_d = irt_pkg::FLD_WORK_MIN;
        end
      end
      irt_pkg::REQ_INC: begin
        unique case (phase_q) inside
          irt_pkg::PH_SETUP, irt_pkg::PH_DONE: begin
            save    = (phase_q == irt_pkg::PH_SETUP);
            index_d = 7'd1;
            phase_d = irt_pkg::PH_WORK;
            rem_d   = work_ms;
          end
          irt_pkg::PH_PAUSED: phase_d = resume_q;
          default: ;
        endcase
      end
      irt_pkg::REQ_DEC: begin
        unique case (phase_q) inside
          irt_pkg::PH_WORK, irt_pkg::PH_REST: begin
            resume_d = phase_q;
            phase_d  = irt_pkg::PH_PAUSED;
          end
          irt_pkg::PH_PAUSED: phase_d = resume_q;
          irt_pkg::PH_DONE:   phase_d = irt_pkg::PH_SETUP;
          default: ;
        endcase
      end
      irt_pkg::REQ_TICK: begin
        if (phase_q == irt_pkg::PH_WORK || phase_q == irt_pkg::PH_REST) begin
          rem_d = rem_sub[23:0];
          if (rem_out) begin
            if (phase_q == irt_pkg::PH_WORK && rest_len_q != '0 && index_q < limit_q) begin
              phase_d = irt_pkg::PH_REST;
              rem_d   = rest_ms;
            end else if (index_q < limit_q) begin
              index_d = index_q + 7'd1;
              phase_d = irt_pkg::PH_WORK;
              rem_d   = work_ms;
            end else begin
              phase_d = irt_pkg::PH_DONE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= irt_pkg::PH_SETUP;
      resume_q      <= irt_pkg::PH_SETUP;
      field_q       <= irt_pkg::FLD_WORK_MIN;
      work_len_q    <= irt_pkg::DEFAULT_WORK;
      work_t_q.mins <= '0;
      work_t_q.secs <= 6'd30;
      rest_len_q    <= '0;
      rest_t_q      <= '0;
      limit_q       <= 7'd1;
      index_q       <= '0;
      rem_q         <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      resume_q   <= resume_d;
      field_q    <= field_d;
      work_len_q <= work_len_d;
      work_t_q   <= work_t_d;
      rest_len_q <= rest_len_d;
      rest_t_q   <= rest_t_d;
      limit_q    <= limit_d;
      index_q    <= index_d;
      rem_q      <= rem_d;
    end
  end

  assign result_o.phase        = irt_pkg::phase_code(phase_d);
  assign result_o.field        = field_d;
  assign result_o.round_now    = index_d;
  assign result_o.rounds_total = limit_d;
  assign result_o.work_seconds = work_len_d;
  assign result_o.rest_seconds = rest_len_d;
  assign result_o.time_left    = rem_d;
  assign result_o.save         = save;

endmodule

`default_nettype wire

// ===== design/interval_round_timer_top.sv =====
// Interval round timer: input register, single-pass state update, result register.
// A request in the input register is processed once the result register is free
// or being taken. Throughput: one request per cycle while results are taken.
// Depends on irt_pkg, irt_cfg and irt_core.
// Reset (rst_ni low, asynchronous) clears both stages and puts the timer in setup.
`default_nettype none

module interval_round_timer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         req_type_i,
  input  wire logic signed [6:0]  rotate_step_i,
  input  wire logic [15:0]        elapsed_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              phase_now_o,
  output logic [2:0]              field_now_o,
  output logic [6:0]              round_now_o,
  output logic [6:0]              rounds_total_o,
  output logic [12:0]             work_seconds_o,
  output logic [12:0]             rest_seconds_o,
  output logic signed [23:0]      time_left_ms_o,
  output logic                    save_settings_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic               in_valid_q;
  irt_pkg::item_t     item_q;
  logic               out_valid_q;
  irt_pkg::result_t   res_q;
  irt_pkg::result_t   res_d;
  irt_pkg::cfg_load_t load;
  logic               in_xfer;
  logic               advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.req     <= req_type_i;
      item_q.step    <= rotate_step_i;
      item_q.elapsed <= elapsed_ms_i;
    end
  end

  irt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .load_o  (load)
  );

  irt_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .load_i    (load),
    .result_o  (res_d)
  );

  // hold the result until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_now_o     = res_q.phase;
  assign field_now_o     = res_q.field;
  assign round_now_o     = res_q.round_now;
  assign rounds_total_o  = res_q.rounds_total;
  assign work_seconds_o  = res_q.work_seconds;
  assign rest_seconds_o  = res_q.rest_seconds;
  assign time_left_ms_o  = $signed(res_q.time_left);
  assign save_settings_o = res_q.save;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while the result register could move");

  a_save_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && save_settings_o) |->
      (phase_now_o == irt_pkg::PH_SETUP_CODE || phase_now_o == irt_pkg::PH_WORK_CODE))
    else $error("save strobe outside a start or a return to setup");

  a_work_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (work_seconds_o != '0 && rounds_total_o != '0))
    else $error("work length or round count reached zero");

  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && phase_now_o == irt_pkg::PH_WORK_CODE) |-> (round_now_o != '0))
    else $error("work phase without a round");

endmodule

`default_nettype wire
